// File: hw/rtl/ubxr_pkg.sv
// ----------------------------------------------------------------------------
// ubxr_pkg
// Shared types and constants for the UBX frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ubxr_pkg;

  // sync pair that opens every frame
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // reset value of the maximum payload length register
  localparam logic [15:0] MAX_LEN_RESET = 16'd256;

  // end-of-frame status codes
  localparam logic [1:0] STATUS_GOOD     = 2'd0;
  localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  // parser phases
  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_L   = 4'd4,
    PH_LEN_H   = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CKA     = 4'd7,
    PH_CKB     = 4'd8
  } phase_t;

  // one received byte handed from the input register to the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } beat_t;

  // one result beat
  typedef struct packed {
    logic        is_end;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_len;
    logic [1:0]  frame_status;
  } result_t;

  // parser to output buffer
  typedef struct packed {
    logic    push;
    result_t res;
  } push_t;

endpackage

`default_nettype wire

// File: hw/rtl/ubxr_in_if.sv
// ----------------------------------------------------------------------------
// ubxr_in_if
// Received byte channel: valid/ready handshake with one byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ubxr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ubxr_out_if.sv
// ----------------------------------------------------------------------------
// ubxr_out_if
// Result channel: payload bytes and end-of-frame status beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface ubxr_out_if;
  logic        valid;
  logic        ready;
  logic        is_end;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic [7:0]  msg_class;
  logic [7:0]  msg_id;
  logic [15:0] payload_len;
  logic [1:0]  frame_status;

  modport source (output valid, output is_end, output data_byte, output byte_index,
                  output msg_class, output msg_id, output payload_len,
                  output frame_status, input ready);
  modport sink   (input valid, input is_end, input data_byte, input byte_index,
                  input msg_class, input msg_id, input payload_len,
                  input frame_status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ubxr_in_stage.sv
// ----------------------------------------------------------------------------
// ubxr_in_stage
// Input register: holds one received byte until the parser can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxr_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_data,
  input  wire logic           room,
  output ubxr_pkg::beat_t     issue
);
  import ubxr_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       fire;
  logic       consume;

  // handshake
  assign consume  = valid_r & room;
  assign in_ready = ~valid_r | room;
  assign fire     = in_valid & in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (fire) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // byte register, no reset needed
  always_ff @(posedge clk) begin
    if (fire) begin
      data_r <= in_data;
    end
  end

  assign issue.valid = consume;
  assign issue.data  = data_r;

endmodule

`default_nettype wire

// File: hw/rtl/ubxr_parser.sv
// ----------------------------------------------------------------------------
// ubxr_parser
// Frame state machine, Fletcher-8 checksum and length limit register.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxr_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [15:0]     cfg_wdata,
  input  wire ubxr_pkg::beat_t issue,
  output ubxr_pkg::push_t      push
);
  import ubxr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  cka_r, cka_nxt;
  logic [15:0] max_len_r;

  logic [7:0]  b;
  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] len_full;
  logic [15:0] seen_inc;

  assign b        = issue.data;
  assign add_a    = sum_a_r + b;
  assign add_b    = sum_b_r + add_a;
  assign len_full = {b, len_r[7:0]};
  assign seen_inc = seen_r + 16'd1;

  // length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      class_r <= '0;
      id_r    <= '0;
      len_r   <= '0;
      seen_r  <= '0;
      sum_a_r <= '0;
      sum_b_r <= '0;
      cka_r   <= '0;
    end else if (issue.valid) begin
      phase_r <= phase_nxt;
      class_r <= class_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      cka_r   <= cka_nxt;
    end
  end

  // next state and result
  always_comb begin
    phase_nxt = phase_r;
    class_nxt = class_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    cka_nxt   = cka_r;

    push.push             = 1'b0;
    push.res.is_end       = 1'b0;
    push.res.data_byte    = '0;
    push.res.byte_index   = '0;
    push.res.msg_class    = class_r;
    push.res.msg_id       = id_r;
    push.res.payload_len  = len_r;
    push.res.frame_status = STATUS_GOOD;

    case (phase_r)
      PH_SYNC1: begin
        if (b == SYNC_FIRST) begin
          phase_nxt = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        // a wrong second byte is not retried as a first sync byte
        if (b == SYNC_SECOND) begin
          phase_nxt = PH_CLASS;
          sum_a_nxt = '0;
          sum_b_nxt = '0;
        end else begin
          phase_nxt = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        class_nxt = b;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt    = b;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_LEN_L;
      end
      PH_LEN_L: begin
        len_nxt   = {8'd0, b};
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_LEN_H;
      end
      PH_LEN_H: begin
        len_nxt   = len_full;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        seen_nxt  = '0;
        if (len_full > max_len_r) begin
          // oversize frame: report and hunt again
          phase_nxt              = PH_SYNC1;
          push.push              = 1'b1;
          push.res.is_end        = 1'b1;
          push.res.payload_len   = len_full;
          push.res.frame_status  = STATUS_TOO_LONG;
        end else if (len_full == 16'd0) begin
          phase_nxt = PH_CKA;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_a_nxt           = add_a;
        sum_b_nxt           = add_b;
        push.push           = 1'b1;
        push.res.data_byte  = b;
        push.res.byte_index = seen_r;
        seen_nxt            = seen_inc;
        if (seen_inc >= len_r) begin
          phase_nxt = PH_CKA;
        end
      end
      PH_CKA: begin
        cka_nxt   = b;
        phase_nxt = PH_CKB;
      end
      PH_CKB: begin
        phase_nxt           = PH_SYNC1;
        push.push           = 1'b1;
        push.res.is_end     = 1'b1;
        push.res.byte_index = len_r;
        if ((cka_r == sum_a_r) && (b == sum_b_r)) begin
          push.res.frame_status = STATUS_GOOD;
        end else begin
          push.res.frame_status = STATUS_BAD_SUM;
        end
      end
      default: begin
        phase_nxt = PH_SYNC1;
      end
    endcase

    push.push = push.push & issue.valid;
  end

endmodule

`default_nettype wire

// File: hw/rtl/ubxr_out_buf.sv
// ----------------------------------------------------------------------------
// ubxr_out_buf
// Result register with one skid entry so the parser keeps going under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxr_out_buf (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ubxr_pkg::push_t push,
  output logic                 room,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ubxr_pkg::result_t    out_res
);
  import ubxr_pkg::*;

  logic    main_v_r, main_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t main_r, skid_r;
  logic    pop;
  logic    load_main_new;
  logic    load_main_skid;
  logic    load_skid;

  assign pop       = main_v_r & out_ready;
  assign room      = ~skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;

  // entry control
  always_comb begin
    main_v_nxt     = main_v_r;
    skid_v_nxt     = skid_v_r;
    load_main_new  = 1'b0;
    load_main_skid = 1'b0;
    load_skid      = 1'b0;
    if (skid_v_r) begin
      // no push arrives while the skid entry is full
      if (pop) begin
        load_main_skid = 1'b1;
        skid_v_nxt     = 1'b0;
      end
    end else if (push.push) begin
      if (!main_v_r || pop) begin
        load_main_new = 1'b1;
        main_v_nxt    = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load_main_new) begin
      main_r <= push.res;
    end else if (load_main_skid) begin
      main_r <= skid_r;
    end
    if (load_skid) begin
      skid_r <= push.res;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ubx_frame_receiver.sv
// ----------------------------------------------------------------------------
// ubx_frame_receiver
// Byte-serial UBX frame parser with Fletcher-8 check and cut-through payload.
// ----------------------------------------------------------------------------
// The receiver takes one serial byte per beat and sustains one byte every
// clock while no result waits in the skid entry. A byte passes an input
// register, then the parser updates its frame state and checksum and writes
// any result into the output register or its skid entry. Payload bytes come
// out with their index as they arrive; after the second checksum byte, or
// after an oversize length field, one end beat carries the status. The
// output register has one skid entry behind it: input stalls only once a
// result waits in that entry. cfg_we/cfg_wdata set the maximum payload length
// (256 after reset); write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  ubxr_in_if.sink          in_ch,
  ubxr_out_if.source       out_ch
);
  import ubxr_pkg::*;

  beat_t   issue;
  push_t   push;
  result_t res;
  logic    room;
  logic    in_ready;
  logic    out_valid;

  // input register
  ubxr_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_data  (in_ch.rx_byte),
    .room     (room),
    .issue    (issue)
  );

  // frame parser
  ubxr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .issue     (issue),
    .push      (push)
  );

  // result register and skid
  ubxr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  // channel hookup
  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.is_end       = res.is_end;
  assign out_ch.data_byte    = res.data_byte;
  assign out_ch.byte_index   = res.byte_index;
  assign out_ch.msg_class    = res.msg_class;
  assign out_ch.msg_id       = res.msg_id;
  assign out_ch.payload_len  = res.payload_len;
  assign out_ch.frame_status = res.frame_status;

endmodule

`default_nettype wire
